// File: rtl/zlh_pkg.sv
// Package for the ZIP local header name extractor.
// Holds the walk phase type, header offsets, signature bytes and result types.
// No dependencies.
package zlh_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_BADSIG = 3'd1,
		PH_NAME   = 3'd2,
		PH_EXTRA  = 3'd3,
		PH_DATA   = 3'd4,
		PH_IGNORE = 3'd5
	} phase_t;

	localparam int OFF_W = 5;

	localparam logic [OFF_W-1:0] SIG_LAST   = 5'd3;
	localparam logic [OFF_W-1:0] OFF_SIZE0  = 5'd18;
	localparam logic [OFF_W-1:0] OFF_SIZE1  = 5'd19;
	localparam logic [OFF_W-1:0] OFF_SIZE2  = 5'd20;
	localparam logic [OFF_W-1:0] OFF_SIZE3  = 5'd21;
	localparam logic [OFF_W-1:0] OFF_NLEN0  = 5'd26;
	localparam logic [OFF_W-1:0] OFF_NLEN1  = 5'd27;
	localparam logic [OFF_W-1:0] OFF_XLEN0  = 5'd28;
	localparam logic [OFF_W-1:0] OFF_XLEN1  = 5'd29;
	localparam logic [OFF_W-1:0] HDR_LAST   = 5'd29;

	localparam logic [7:0] SIG_B0 = 8'h50;
	localparam logic [7:0] SIG_B1 = 8'h4B;
	localparam logic [7:0] SIG_B2 = 8'h03;
	localparam logic [7:0] SIG_B3 = 8'h04;

	localparam logic KIND_NAME   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic ST_FINISHED  = 1'b0;
	localparam logic ST_TRUNCATED = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] name_char;
		logic       name_last;
		logic       name_empty;
		logic       walk_status;
		logic       run_last;
	} result_t;

	// results of one byte: up to two, in order
	typedef struct packed {
		logic       valid;
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} parse_out_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = SIG_B0;
			2'd1: b = SIG_B1;
			2'd2: b = SIG_B2;
			default: b = SIG_B3;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/zlh_parser.sv
// Input register and header walk state machine.
// Produces up to two results per beat for the result buffer.
// Depends on zlh_pkg.
module zlh_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_archive,
	input  logic               load_ok,
	output zlh_pkg::parse_out_t po
);
	import zlh_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              end_s1;
	logic              fire;

	phase_t            phase_q, phase_d;
	logic [OFF_W-1:0]  hdr_off_q, off_d;
	logic [31:0]       dlen_q, dlen_d;
	logic [15:0]       nlen_q, nlen_d;
	logic [15:0]       xlen_q, xlen_d;
	logic [31:0]       rem_q, rem_d;

	assign fire     = valid_s1 && load_ok;
	assign in_stall = valid_s1 && !load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || fire) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && (!valid_s1 || fire)) begin
			byte_s1 <= data_byte;
			end_s1  <= end_of_archive;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_off_q <= '0;
			dlen_q    <= '0;
			nlen_q    <= '0;
			xlen_q    <= '0;
			rem_q     <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			hdr_off_q <= off_d;
			dlen_q    <= dlen_d;
			nlen_q    <= nlen_d;
			xlen_q    <= xlen_d;
			rem_q     <= rem_d;
		end
	end

	always_comb begin
		logic        sig_bad;
		logic        skip;
		logic        clean;
		logic [31:0] rem_dec;
		result_t     res0;
		result_t     res1;
		result_t     st;
		logic [1:0]  n;

		phase_d = phase_q;
		off_d   = hdr_off_q;
		dlen_d  = dlen_q;
		nlen_d  = nlen_q;
		xlen_d  = xlen_q;
		rem_d   = rem_q;
		sig_bad = 1'b0;
		skip    = 1'b0;
		clean   = 1'b0;
		rem_dec = rem_q - 32'd1;
		res0    = '0;
		res1    = '0;
		st      = '0;
		n       = 2'd0;

		case (phase_q)
			PH_HEADER, PH_BADSIG: begin
				if (hdr_off_q <= SIG_LAST) begin
					sig_bad = (phase_q == PH_BADSIG) ||
						(byte_s1 != sig_byte(hdr_off_q[1:0]));
					if (sig_bad) begin
						phase_d = PH_BADSIG;
					end
					if (sig_bad && hdr_off_q == SIG_LAST) begin
						phase_d = PH_IGNORE;
						off_d   = '0;
						skip    = 1'b1;
					end
				end else begin
					case (hdr_off_q)
						OFF_SIZE0: dlen_d = {24'h0, byte_s1};
						OFF_SIZE1: dlen_d[15:8] = byte_s1;
						OFF_SIZE2: dlen_d[23:16] = byte_s1;
						OFF_SIZE3: dlen_d[31:24] = byte_s1;
						OFF_NLEN0: nlen_d = {8'h0, byte_s1};
						OFF_NLEN1: nlen_d[15:8] = byte_s1;
						OFF_XLEN0: xlen_d = {8'h0, byte_s1};
						OFF_XLEN1: xlen_d[15:8] = byte_s1;
						default: ;
					endcase
				end
				if (!skip) begin
					if (hdr_off_q >= HDR_LAST) begin
						off_d = '0;
						if (nlen_d != 16'h0) begin
							phase_d = PH_NAME;
							rem_d   = {16'h0, nlen_d};
						end else begin
							res0.kind       = KIND_NAME;
							res0.name_last  = 1'b1;
							res0.name_empty = 1'b1;
							n = 2'd1;
							if (xlen_d != 16'h0) begin
								phase_d = PH_EXTRA;
								rem_d   = {16'h0, xlen_d};
							end else if (dlen_d != 32'h0) begin
								phase_d = PH_DATA;
								rem_d   = dlen_d;
							end else begin
								phase_d = PH_HEADER;
							end
						end
					end else begin
						off_d = hdr_off_q + 5'd1;
					end
				end
			end
			PH_NAME: begin
				rem_d          = rem_dec;
				res0.kind      = KIND_NAME;
				res0.name_char = byte_s1;
				n              = 2'd1;
				if (rem_dec == 32'h0) begin
					res0.name_last = 1'b1;
					if (xlen_q != 16'h0) begin
						phase_d = PH_EXTRA;
						rem_d   = {16'h0, xlen_q};
					end else if (dlen_q != 32'h0) begin
						phase_d = PH_DATA;
						rem_d   = dlen_q;
					end else begin
						phase_d = PH_HEADER;
						off_d   = '0;
					end
				end
			end
			PH_EXTRA: begin
				rem_d = rem_dec;
				if (rem_dec == 32'h0) begin
					if (dlen_q != 32'h0) begin
						phase_d = PH_DATA;
						rem_d   = dlen_q;
					end else begin
						phase_d = PH_HEADER;
						off_d   = '0;
					end
				end
			end
			PH_DATA: begin
				rem_d = rem_dec;
				if (rem_dec == 32'h0) begin
					phase_d = PH_HEADER;
					off_d   = '0;
				end
			end
			default: begin
				phase_d = PH_IGNORE;
			end
		endcase

		if (end_s1) begin
			clean = (phase_d == PH_IGNORE) ||
				(phase_d == PH_HEADER && off_d == '0);
			st.kind        = KIND_STATUS;
			st.walk_status = clean ? ST_FINISHED : ST_TRUNCATED;
			if (n == 2'd0) begin
				res0 = st;
			end else begin
				res1 = st;
			end
			n       = n + 2'd1;
			phase_d = PH_HEADER;
			off_d   = '0;
			dlen_d  = '0;
			nlen_d  = '0;
			xlen_d  = '0;
			rem_d   = '0;
		end

		if (n == 2'd1) begin
			res0.run_last = 1'b1;
		end
		if (n == 2'd2) begin
			res1.run_last = 1'b1;
		end

		po.valid = valid_s1;
		po.cnt   = n;
		po.r0    = res0;
		po.r1    = res1;
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NAME || phase_q == PH_EXTRA || phase_q == PH_DATA)
		|-> rem_q != 32'h0)
		else $error("length count zero inside name, extra or data");

	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_off_q <= HDR_LAST)
		else $error("header offset beyond header");

	a_off_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER && phase_q != PH_BADSIG) |-> hdr_off_q == '0)
		else $error("header offset not cleared outside header");

endmodule

// File: rtl/zlh_result_buf.sv
// Two-slot result register between the parser and the output channel.
// Loads all results of one beat at once and presents them in order.
// Depends on zlh_pkg.
module zlh_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  zlh_pkg::parse_out_t po,
	output logic                load_ok,
	output logic                out_valid,
	input  logic                out_stall,
	output zlh_pkg::result_t    head
);
	import zlh_pkg::*;

	logic [1:0] cnt_q;
	result_t    slot_a_q;
	result_t    slot_b_q;
	logic       take;
	logic       load;

	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && !out_stall;
	assign load_ok   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
	assign load      = po.valid && load_ok;
	assign head      = slot_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= po.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_a_q <= po.r0;
			slot_b_q <= po.r1;
		end else if (take) begin
			slot_a_q <= slot_b_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result count out of range");

	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !slot_a_q.run_last && slot_b_q.run_last)
		else $error("run_last misplaced in result pair");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> slot_a_q.run_last)
		else $error("lone result without run_last");

endmodule

// File: rtl/zip_local_header_name_extractor.sv
// ZIP local header name extractor, top level.
// Path: a byte beat is registered in the parser's input register; its results are then loaded into
// the result register once it has room, and are offered to the output from there.
// Throughput: one byte per cycle while out_stall is low; a byte that yields two results
// (a name or marker plus the end status) holds the input while the result register drains.
// Reset (arst_n low, asynchronous): walk at header start, counts and lengths cleared.
// Depends on zlh_pkg, zlh_parser, zlh_result_buf.
module zip_local_header_name_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_archive,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] name_char,
	output logic       name_last,
	output logic       name_empty,
	output logic       walk_status,
	output logic       run_last
);
	import zlh_pkg::*;

	parse_out_t po;
	result_t    head;
	logic       load_ok;

	zlh_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_archive (end_of_archive),
		.load_ok        (load_ok),
		.po             (po)
	);

	zlh_result_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.po        (po),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind        = head.kind;
	assign name_char   = head.name_char;
	assign name_last   = head.name_last;
	assign name_empty  = head.name_empty;
	assign walk_status = head.walk_status;
	assign run_last    = head.run_last;

endmodule
